// ===== hw/rtl/sts_pkg.sv =====
// Shared types, constants and helpers for the stride turn scheduler.
// Used by sts_div, stride_turn_scheduler and the testbench; depends on nothing else.
package sts_pkg;

   localparam int MAX_ENTRIES = 32;
   localparam int TIME_BITS   = 32;

   localparam int IDX_BITS   = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS   = $clog2(MAX_ENTRIES + 1);
   localparam int CMD_BITS   = 2;
   localparam int ID_BITS    = 5;
   localparam int SPEED_BITS = 7;
   localparam int COUNT_BITS = 6;
   localparam int OUT_TIME_BITS = 32;
   localparam int RAM_WIDTH  = TIME_BITS + SPEED_BITS;

   localparam logic [SPEED_BITS-1:0] STRIDE_BASE = SPEED_BITS'(100);
   localparam logic [TIME_BITS-1:0]  TIME_HALF   = TIME_BITS'(1) << (TIME_BITS - 1);

   localparam logic [CMD_BITS-1:0] CMD_TURN   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_LOAD   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd2;

   typedef struct packed {
      logic                  start;
      logic [SPEED_BITS-1:0] speed;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [SPEED_BITS-1:0] quotient;
   } div_rsp_type;

   // Number of entries taking part, clamped to the table size.
   function automatic logic [CNT_BITS-1:0] active_count(input logic [COUNT_BITS-1:0] cnt);
      logic [CNT_BITS-1:0] res;
      if (32'(cnt) > MAX_ENTRIES) begin
         res = CNT_BITS'(MAX_ENTRIES);
      end else begin
         res = CNT_BITS'(cnt);
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/sts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module sts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sts_div.sv =====
// Restoring divider that forms the stride, 100 divided by speed, one bit a cycle.
// Depends on sts_pkg.
module sts_div (
   input  logic                 clock,
   input  logic                 reset,
   input  sts_pkg::div_req_type req,
   output sts_pkg::div_rsp_type rsp
);

   localparam int STEP_BITS = $clog2(sts_pkg::SPEED_BITS);

   logic [sts_pkg::SPEED_BITS-1:0] rem_ff, rem_in;
   logic [sts_pkg::SPEED_BITS-1:0] quo_ff, quo_in;
   logic [sts_pkg::SPEED_BITS-1:0] dsr_ff, dsr_in;
   logic [STEP_BITS-1:0]           step_ff, step_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [sts_pkg::SPEED_BITS:0]   trial;
   logic                           fits;

   // The quotient register first holds the dividend; its bits shift out as
   // quotient bits shift in.
   assign trial = {rem_ff, quo_ff[sts_pkg::SPEED_BITS-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = sts_pkg::STRIDE_BASE;
         dsr_in  = (req.speed == '0) ? sts_pkg::SPEED_BITS'(1) : req.speed;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = sts_pkg::SPEED_BITS'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[sts_pkg::SPEED_BITS-1:0];
         end
         quo_in  = {quo_ff[sts_pkg::SPEED_BITS-2:0], fits};
         step_in = step_ff + STEP_BITS'(1);
         if (step_ff == STEP_BITS'(sts_pkg::SPEED_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== hw/rtl/stride_turn_scheduler.sv =====
// Top level of the stride turn scheduler: command sequencer, scan compare and entry table.
// Depends on sts_pkg, sts_ram and sts_div.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_tvalid/req_tready  | tuser: cmd; tdata: entry_id, speed
//   rsp     | out       | rsp_tvalid/rsp_tready  | tuser: found; tdata: chosen_id, turn_time
//   csr     | in        | csr_wen                | csr_wdata: entry_count
//
// One word is handled at a time. A load waits on the bit-serial stride divider
// (seven quotient bits, one per cycle). A turn reads the entries in use
// (entry_count, capped at 32) in order: the shared compare unit visits one entry
// a cycle through the table's registered read port. Remove, unknown commands, an
// out-of-range load and a turn with no entries in use go straight to the output
// state. Reset is synchronous and clears all live marks, the last served
// time and entry_count; the time and stride table holds no reset value.
// A finished word waits in the output register, and the next request word is
// taken while it waits; only a second result stalls on rsp_tready.
module stride_turn_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [4:0] entry_id, [11:5] speed, [15:12] zero
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [4:0] chosen_id, [36:5] turn_time, [39:37] zero
   output logic [0:0]  rsp_tuser,   // [0] found
   input  logic        csr_wen,
   input  logic [5:0]  csr_wdata    // entry_count
);

   localparam int TB = sts_pkg::TIME_BITS;
   localparam int IB = sts_pkg::IDX_BITS;
   localparam int CB = sts_pkg::CNT_BITS;
   localparam int SB = sts_pkg::SPEED_BITS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_UPD  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]                      state_ff, state_in;
   logic [sts_pkg::COUNT_BITS-1:0]  count_ff;
   logic [TB-1:0]                   last_ff, last_in;
   logic [sts_pkg::MAX_ENTRIES-1:0] live_ff, live_in;
   logic [IB-1:0]                   id_ff, id_in;
   logic [CB-1:0]                   issue_ff, issue_in;
   logic                            cmp_vld_ff, cmp_vld_in;
   logic [IB-1:0]                   cmp_idx_ff, cmp_idx_in;
   logic                            have_ff, have_in;
   logic [IB-1:0]                   best_idx_ff, best_idx_in;
   logic [TB-1:0]                   best_key_ff, best_key_in;
   logic [TB-1:0]                   best_time_ff, best_time_in;
   logic [SB-1:0]                   best_stride_ff, best_stride_in;
   logic [sts_pkg::ID_BITS-1:0]     res_id_ff, res_id_in;
   logic [sts_pkg::OUT_TIME_BITS-1:0] res_time_ff, res_time_in;
   logic                            res_found_ff, res_found_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [39:0]                     rsp_data_ff, rsp_data_in;
   logic                            rsp_user_ff, rsp_user_in;

   logic [sts_pkg::CMD_BITS-1:0]    in_cmd;
   logic [sts_pkg::ID_BITS-1:0]     in_id;
   logic [SB-1:0]                   in_speed;
   logic [CB-1:0]                   active;
   logic                            accept;
   logic                            id_ok;

   logic                            ram_we;
   logic [IB-1:0]                   ram_waddr;
   logic [sts_pkg::RAM_WIDTH-1:0]   ram_wdata;
   logic [IB-1:0]                   ram_raddr;
   logic [sts_pkg::RAM_WIDTH-1:0]   ram_rdata;
   logic [TB-1:0]                   rd_time;
   logic [SB-1:0]                   rd_stride;
   logic [TB-1:0]                   cur_key;

   sts_pkg::div_req_type div_req;
   sts_pkg::div_rsp_type div_rsp;

   assign in_cmd   = req_tuser[1:0];
   assign in_id    = req_tdata[4:0];
   assign in_speed = req_tdata[11:5];
   assign active   = sts_pkg::active_count(count_ff);
   assign accept   = req_tvalid && req_tready;
   assign id_ok    = 32'(in_id) < 32'(active);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Each table word holds an entry's stride above its next turn time.
   assign rd_time   = ram_rdata[TB-1:0];
   assign rd_stride = ram_rdata[sts_pkg::RAM_WIDTH-1:TB];

   // Wrap-safe order key: the signed distance from the last served time,
   // biased to unsigned by flipping its top bit.
   assign cur_key = (rd_time - last_ff) ^ sts_pkg::TIME_HALF;

   sts_ram #(
      .WIDTH(sts_pkg::RAM_WIDTH),
      .DEPTH(sts_pkg::MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   sts_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in       = state_ff;
      last_in        = last_ff;
      live_in        = live_ff;
      id_in          = id_ff;
      issue_in       = issue_ff;
      cmp_vld_in     = cmp_vld_ff;
      cmp_idx_in     = cmp_idx_ff;
      have_in        = have_ff;
      best_idx_in    = best_idx_ff;
      best_key_in    = best_key_ff;
      best_time_in   = best_time_ff;
      best_stride_in = best_stride_ff;
      res_id_in      = res_id_ff;
      res_time_in    = res_time_ff;
      res_found_in   = res_found_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      div_req.start  = 1'b0;
      div_req.speed  = in_speed;
      ram_we         = 1'b0;
      ram_waddr      = best_idx_ff;
      ram_wdata      = {best_stride_ff, best_time_ff + TB'(best_stride_ff)};
      ram_raddr      = issue_ff[IB-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_id_in    = '0;
               res_time_in  = '0;
               res_found_in = 1'b0;
               id_in        = IB'(in_id);
               cmp_vld_in   = 1'b0;
               state_in     = S_OUT;
               unique case (in_cmd)
                  sts_pkg::CMD_LOAD: begin
                     if (id_ok) begin
                        div_req.start = 1'b1;
                        state_in      = S_DIV;
                     end
                  end
                  sts_pkg::CMD_REMOVE: begin
                     if (id_ok) begin
                        live_in[IB'(in_id)] = 1'b0;
                     end
                  end
                  sts_pkg::CMD_TURN: begin
                     if (active != '0) begin
                        issue_in = '0;
                        have_in  = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               ram_we         = 1'b1;
               ram_waddr      = id_ff;
               ram_wdata      = {div_rsp.quotient, TB'(div_rsp.quotient)};
               live_in[id_ff] = 1'b1;
               state_in       = S_OUT;
            end
         end
         S_SCAN: begin
            // Issue one table read a cycle; compare its data in the cycle after.
            if (issue_ff < active) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[IB-1:0];
               issue_in   = issue_ff + CB'(1);
            end else begin
               cmp_vld_in = 1'b0;
            end
            if (cmp_vld_ff && live_ff[cmp_idx_ff] && (!have_ff || cur_key < best_key_ff)) begin
               have_in        = 1'b1;
               best_idx_in    = cmp_idx_ff;
               best_key_in    = cur_key;
               best_time_in   = rd_time;
               best_stride_in = rd_stride;
            end
            if (issue_ff == active && !cmp_vld_ff) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            if (have_ff) begin
               ram_we       = 1'b1;
               last_in      = best_time_ff;
               res_found_in = 1'b1;
               res_id_in    = sts_pkg::ID_BITS'(best_idx_ff);
               res_time_in  = sts_pkg::OUT_TIME_BITS'(best_time_ff);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, res_time_ff, res_id_ff};
               rsp_user_in  = res_found_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         last_ff      <= '0;
         live_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         live_ff      <= live_in;
         cmp_vld_ff   <= cmp_vld_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            count_ff <= csr_wdata;
         end
      end
      id_ff          <= id_in;
      issue_ff       <= issue_in;
      cmp_idx_ff     <= cmp_idx_in;
      best_idx_ff    <= best_idx_in;
      best_key_ff    <= best_key_in;
      best_time_ff   <= best_time_in;
      best_stride_ff <= best_stride_in;
      res_id_ff      <= res_id_in;
      res_time_ff    <= res_time_in;
      res_found_ff   <= res_found_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_user_ff    <= rsp_user_in;
   end

`ifndef SYNTHESIS
   // A request word is never followed by another in the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken on two consecutive cycles");

   // The divider only reports a stride while a load is waiting for it.
   a_div_done_in_load: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("stride divider finished outside a load");

   // The winner of a scan is always a live entry.
   a_winner_live: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_UPD) && have_ff) |-> live_ff[best_idx_ff])
      else $error("scan selected an entry that is not live");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for stride_turn_scheduler: directed plan, then randomized phases.
// Depends on sts_pkg and the stride_turn_scheduler RTL; expected words come from a
// scheduling model kept inside this file, or are typed into the directed plan.
`timescale 1ns / 1ps

module testbench;

   // Command code the block must ignore, answering with the all-zero word.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Covers the longest turn with margin before a CSR write.
   localparam int DRAIN_CYCLES  = 60;
   localparam int STALL_LIMIT   = 3000;
   localparam int MAX_REPORTS   = 40;

   typedef struct packed {
      logic [4:0]  chosen_id;
      logic [31:0] turn_time;
      logic        found;
   } sched_rsp_type;

   localparam sched_rsp_type ZERO_RSP = '0;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      logic [1:0]    cmd;
      logic [4:0]    id;
      logic [6:0]    speed;
      logic [5:0]    count;    // only used by CSR rows
      logic          typed;    // expectation typed in the row instead of predicted
      sched_rsp_type rsp;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_wen = 1'b0;
   logic [5:0]  csr_wdata = '0;

   // Scheduling model state, a private copy of what the block should hold.
   logic [31:0] model_time [sts_pkg::MAX_ENTRIES];
   logic [6:0]  model_speed [sts_pkg::MAX_ENTRIES];
   logic        model_live [sts_pkg::MAX_ENTRIES];
   logic [31:0] model_last_served;
   logic [5:0]  model_entry_count;

   sched_rsp_type pending_rsp[$];
   plan_row_type  plan[$];
   int          error_count = 0;
   int          burst_left = 0;
   int          idle_cycles = 0;

   stride_turn_scheduler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stride is 100 divided by the speed; speed zero counts as one, and
   // speeds above 100 give a stride of zero.
   function automatic logic [31:0] stride_for(input logic [6:0] spd);
      int unsigned d;
      d = (spd == 7'd0) ? 1 : spd;
      return 32'(100 / d);
   endfunction

   function automatic int unsigned entries_in_use();
      return (model_entry_count > sts_pkg::MAX_ENTRIES) ? sts_pkg::MAX_ENTRIES
                                                        : model_entry_count;
   endfunction

   // Apply one accepted word to the model and return the word it must produce.
   function automatic sched_rsp_type schedule_word(input logic [1:0] cmd,
                                                   input logic [4:0] id,
                                                   input logic [6:0] spd);
      sched_rsp_type r;
      int unsigned n;
      logic        have;
      int unsigned best;
      logic [31:0] best_key;
      logic [31:0] key;
      r = ZERO_RSP;
      n = entries_in_use();
      have = 1'b0;
      best = 0;
      best_key = '0;
      case (cmd)
         sts_pkg::CMD_LOAD: begin
            if (id < n) begin
               model_speed[id] = spd;
               model_live[id]  = 1'b1;
               model_time[id]  = stride_for(spd);
            end
         end
         sts_pkg::CMD_REMOVE: begin
            if (id < n) model_live[id] = 1'b0;
         end
         sts_pkg::CMD_TURN: begin
            for (int i = 0; i < n; i++) begin
               if (model_live[i]) begin
                  // Signed distance from the last served time, biased so that an
                  // unsigned compare orders times across wrap-around.
                  key = (model_time[i] - model_last_served) + 32'h8000_0000;
                  if (!have || key < best_key) begin
                     have = 1'b1;
                     best = i;
                     best_key = key;
                  end
               end
            end
            if (have) begin
               r.chosen_id = best[4:0];
               r.turn_time = model_time[best];
               r.found = 1'b1;
               model_last_served = model_time[best];
               model_time[best] = model_time[best] + stride_for(model_speed[best]);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int fresh_burst();
      // Now and then a long run with no gaps at all.
      return ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
   endfunction

   // Present one word, wait for it to be taken, and queue its expected result.
   // Called on a rising edge; returns on the accepting edge, or after an idle gap.
   task automatic send_word(input logic [1:0] cmd, input logic [4:0] id, input logic [6:0] spd,
                            input logic typed, input sched_rsp_type typed_rsp);
      sched_rsp_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0000, spd, id};
      do @(posedge clock); while (!req_tready);
      predicted = schedule_word(cmd, id, spd);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = fresh_burst();
      end
   endtask

   // Hold the sender off until every expected word has come back, then let the
   // block settle so that a register write finds it idle.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_entry_count(input logic [5:0] value);
      wait_drained();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      model_entry_count = value;
      csr_wen <= 1'b0;
   endtask

   // One random word. Most ids land inside the active range so that loads and
   // removes actually change the table; speeds lean toward the extremes.
   task automatic send_random_word();
      int unsigned n;
      int unsigned pick;
      logic [1:0]  cmd;
      logic [4:0]  id;
      logic [6:0]  spd;
      n = entries_in_use();
      pick = $urandom_range(0, 99);
      if (pick < 50)      cmd = sts_pkg::CMD_TURN;
      else if (pick < 80) cmd = sts_pkg::CMD_LOAD;
      else if (pick < 95) cmd = sts_pkg::CMD_REMOVE;
      else                cmd = CMD_UNUSED;
      if (n > 0 && $urandom_range(0, 99) < 85) id = 5'($urandom_range(0, n - 1));
      else id = 5'($urandom_range(0, 31));
      case ($urandom_range(0, 9))
         0:       spd = 7'd0;
         1:       spd = 7'd100;
         2:       spd = 7'($urandom_range(101, 127));
         3:       spd = 7'd1;
         default: spd = 7'($urandom_range(0, 127));
      endcase
      send_word(cmd, id, spd, 1'b0, ZERO_RSP);
   endtask

   // The receiver stalls on its own schedule: ready runs and stall runs of
   // random length, with occasional long stretches of uninterrupted ready.
   initial begin
      forever begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(20, 80)) begin
               rsp_tready <= 1'b1;
               @(posedge clock);
            end
         end else begin
            repeat ($urandom_range(1, 6)) begin
               rsp_tready <= 1'b1;
               @(posedge clock);
            end
            repeat ($urandom_range(1, 12)) begin
               rsp_tready <= 1'b0;
               @(posedge clock);
            end
         end
      end
   end

   // Result checker: every accepted word is compared field by field with the
   // oldest expectation.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin : check_word
         sched_rsp_type got;
         sched_rsp_type want;
         got.chosen_id = rsp_tdata[4:0];
         got.turn_time = rsp_tdata[36:5];
         got.found     = rsp_tuser[0];
         if (pending_rsp.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected result word, id %0d time %0d found %0d",
                        $realtime, got.chosen_id, got.turn_time, got.found);
         end else begin
            want = pending_rsp.pop_front();
            if (got.chosen_id !== want.chosen_id) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: chosen_id mismatch, expected %0d actual %0d",
                           $realtime, want.chosen_id, got.chosen_id);
            end
            if (got.turn_time !== want.turn_time) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: turn_time mismatch, expected %0d actual %0d",
                           $realtime, want.turn_time, got.turn_time);
            end
            if (got.found !== want.found) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: found mismatch, expected %0d actual %0d",
                           $realtime, want.found, got.found);
            end
         end
      end
   end

   // Watchdog: a long stretch with no word moving on either channel means the
   // block is hung.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Directed plan. Rows whose result is obvious carry it typed in; the rest
   // (the actual scheduling decisions) are left to the model.
   initial begin
      // After reset nothing is live and entry_count is zero, so everything is ignored.
      plan.push_back('{ROW_WORD, sts_pkg::CMD_TURN,   5'd0,  7'd0,   6'd0,  1'b1, ZERO_RSP});
      plan.push_back('{ROW_WORD, sts_pkg::CMD_LOAD,   5'd0,  7'd50,  6'd0,  1'b1, ZERO_RSP});
      plan.push_back('{ROW_WORD, sts_pkg::CMD_TURN,   5'd0,  7'd0,   6'd0,  1'b1, ZERO_RSP});
      plan.push_back('{ROW_CSR,  sts_pkg::CMD_TURN,   5'd0,  7'd0,   6'd32, 1'b0, ZERO_RSP});
      // Speed zero behaves as one; speed 100 gives stride one; above 100 stride zero.
      plan.push_back('{ROW_WORD, sts_pkg::CMD_LOAD,   5'd0,  7'd0,   6'd0,  1'b1, ZERO_RSP});
      plan.push_back('{ROW_WORD, sts_pkg::CMD_LOAD,   5'd31, 7'd100, 6'd0,  1'b1, ZERO_RSP});
      plan.push_back('{ROW_WORD, sts_pkg::CMD_LOAD,   5'd5,  7'd127, 6'd0,  1'b1, ZERO_RSP});
      plan.push_back('{ROW_WORD, sts_pkg::CMD_LOAD,   5'd3,  7'd1,   6'd0,  1'b1, ZERO_RSP});
      // The zero-stride entry wins every turn until it is removed.
      plan.push_back('{ROW_WORD, sts_pkg::CMD_TURN,   5'd0,  7'd0,   6'd0,  1'b0, ZERO_RSP});
      plan.push_back('{ROW_WORD, sts_pkg::CMD_TURN,   5'd0,  7'd0,   6'd0,  1'b0, ZERO_RSP});
      plan.push_back('{ROW_WORD, sts_pkg::CMD_REMOVE, 5'd5,  7'd0,   6'd0,  1'b1, ZERO_RSP});
      plan.push_back('{ROW_WORD, sts_pkg::CMD_TURN,   5'd0,  7'd0,   6'd0,  1'b0, ZERO_RSP});
      plan.push_back('{ROW_WORD, sts_pkg::CMD_TURN,   5'd0,  7'd0,   6'd0,  1'b0, ZERO_RSP});
      plan.push_back('{ROW_WORD, CMD_UNUSED,          5'd31, 7'd127, 6'd0,  1'b1, ZERO_RSP});
      plan.push_back('{ROW_WORD, sts_pkg::CMD_REMOVE, 5'd31, 7'd0,   6'd0,  1'b1, ZERO_RSP});
      // Entries 0 and 3 tie at time 100: the lower id goes first.
      plan.push_back('{ROW_WORD, sts_pkg::CMD_TURN,   5'd0,  7'd0,   6'd0,  1'b0, ZERO_RSP});
      plan.push_back('{ROW_WORD, sts_pkg::CMD_TURN,   5'd0,  7'd0,   6'd0,  1'b0, ZERO_RSP});
      // Reloading a live entry restarts its time, which now lies behind the
      // last served time.
      plan.push_back('{ROW_WORD, sts_pkg::CMD_LOAD,   5'd3,  7'd50,  6'd0,  1'b1, ZERO_RSP});
      plan.push_back('{ROW_WORD, sts_pkg::CMD_TURN,   5'd0,  7'd0,   6'd0,  1'b0, ZERO_RSP});
      plan.push_back('{ROW_WORD, sts_pkg::CMD_REMOVE, 5'd7,  7'd0,   6'd0,  1'b1, ZERO_RSP});
      // Ids at or above entry_count are ignored and never chosen.
      plan.push_back('{ROW_CSR,  sts_pkg::CMD_TURN,   5'd0,  7'd0,   6'd1,  1'b0, ZERO_RSP});
      plan.push_back('{ROW_WORD, sts_pkg::CMD_LOAD,   5'd1,  7'd10,  6'd0,  1'b1, ZERO_RSP});
      plan.push_back('{ROW_WORD, sts_pkg::CMD_TURN,   5'd0,  7'd0,   6'd0,  1'b0, ZERO_RSP});
      plan.push_back('{ROW_CSR,  sts_pkg::CMD_TURN,   5'd0,  7'd0,   6'd0,  1'b0, ZERO_RSP});
      plan.push_back('{ROW_WORD, sts_pkg::CMD_TURN,   5'd0,  7'd0,   6'd0,  1'b1, ZERO_RSP});
   end

   // Main sequence.
   initial begin : main_seq
      logic [5:0] phase_counts [10];
      int         phase_items;
      for (int i = 0; i < sts_pkg::MAX_ENTRIES; i++) model_live[i] = 1'b0;
      model_last_served = '0;
      model_entry_count = '0;
      burst_left = fresh_burst();
      phase_counts = '{6'd1, 6'd2, 6'd32, 6'd0, 6'd63, 6'd31, 6'd33, 6'd8,
                       6'($urandom_range(0, 63)), 6'($urandom_range(3, 32))};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) write_entry_count(plan[i].count);
         else send_word(plan[i].cmd, plan[i].id, plan[i].speed, plan[i].typed, plan[i].rsp);
      end

      // Random phases, each under its own entry_count. Every phase with entries in
      // use opens with a run of loads so that turns find a populated table.
      foreach (phase_counts[p]) begin
         write_entry_count(phase_counts[p]);
         phase_items = (phase_counts[p] == 6'd0) ? 40 : 160;
         repeat ((entries_in_use() < 8) ? entries_in_use() : 8)
            send_word(sts_pkg::CMD_LOAD, 5'($urandom_range(0, entries_in_use() - 1)),
                      7'($urandom_range(0, 127)), 1'b0, ZERO_RSP);
         repeat (phase_items) send_random_word();
      end

      wait_drained();
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/sts_pkg.sv
hw/rtl/sts_ram.sv
hw/rtl/sts_div.sv
hw/rtl/stride_turn_scheduler.sv
verif/testbench.sv
